### hw/rtl/dcpr_pkg.sv
// Shared types and constants for the daisy-chain packet router.
`timescale 1ns / 1ps
package dcpr_pkg;

  // Fixed storage and addressing constants
  localparam int STORE_SLOTS = 7;
  localparam logic [7:0] ADDR_HOST  = 8'd0;
  localparam logic [7:0] ADDR_SELF  = 8'd1;
  localparam logic [7:0] ADDR_BCAST = 8'd255;
  localparam logic [7:0] RESET_CMD  = 8'h08;
  localparam logic [4:0] CODE_RGB8  = 5'd5;
  localparam logic [4:0] CODE_RGB16 = 5'd6;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_EXEC = 2'd1;
  localparam logic [1:0] KIND_RST  = 2'd2;

  // Routing of the packet in progress
  typedef enum logic [1:0] {
    ROUTE_SELF  = 2'd0,
    ROUTE_HOST  = 2'd1,
    ROUTE_BCAST = 2'd2,
    ROUTE_OTHER = 2'd3
  } route_t;

  // Framing state, one-hot
  typedef enum logic [2:0] {
    PH_ADDR = 3'b001,
    PH_CMD  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  // Work descriptor passed from the front to the back
  typedef struct packed {
    logic        err;
    logic        has_tx;
    logic [7:0]  tx_byte;
    logic        has_exec;
    logic [4:0]  cmd_code;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } job_t;

endpackage

### hw/rtl/dcpr_front.sv
// Front end: frames received bytes, routes packets and builds work descriptors.
`timescale 1ns / 1ps
module dcpr_front import dcpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_acc,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       push,
  output job_t       job
);

  phase_t      phase_r, phase_nxt;
  route_t      route_r, route_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [7:0]  store_r   [MAX_PAYLOAD];
  logic [7:0]  store_nxt [MAX_PAYLOAD];
  logic [7:0]  pad       [STORE_SLOTS];
  logic        executes;
  job_t        job_base;

  assign executes = (route_r == ROUTE_SELF) || (route_r == ROUTE_BCAST);

  // Store view padded to the full slot count; missing slots read as zero
  for (genvar g = 0; g < STORE_SLOTS; g++) begin : g_pad
    if (g < MAX_PAYLOAD) begin : g_live
      assign pad[g] = store_nxt[g];
    end else begin : g_zero
      assign pad[g] = '0;
    end
  end

  // Framing and routing decisions
  always_comb begin
    phase_nxt = phase_r;
    route_nxt = route_r;
    cmd_nxt   = cmd_r;
    count_nxt = count_r;
    store_nxt = store_r;
    job_base  = '0;
    if (in_acc) begin
      if (in_op) begin
        job_base.err = 1'b1;
        phase_nxt    = PH_ADDR;
        route_nxt    = ROUTE_SELF;
        cmd_nxt      = '0;
        count_nxt    = '0;
        for (int i = 0; i < MAX_PAYLOAD; i++) store_nxt[i] = '0;
      end else begin
        case (phase_r)
          PH_CMD: begin
            cmd_nxt          = in_rx_byte;
            job_base.has_tx  = (route_r != ROUTE_SELF);
            job_base.tx_byte = in_rx_byte;
            count_nxt        = '0;
            if (in_rx_byte[2:0] == 3'd0) begin
              job_base.has_exec = executes;
              phase_nxt         = PH_ADDR;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
          PH_PAY: begin
            for (int i = 0; i < MAX_PAYLOAD; i++) begin
              if (route_r != ROUTE_OTHER && count_r == 3'(i)) store_nxt[i] = in_rx_byte;
            end
            job_base.has_tx  = (route_r != ROUTE_SELF);
            job_base.tx_byte = in_rx_byte;
            count_nxt        = count_r + 3'd1;
            if (({1'b0, count_r} + 4'd1) >= {1'b0, cmd_r[2:0]}) begin
              job_base.has_exec = executes;
              phase_nxt         = PH_ADDR;
              count_nxt         = '0;
            end
          end
          default: begin
            // waiting for an address byte
            phase_nxt = PH_CMD;
            if (in_rx_byte == ADDR_SELF) begin
              route_nxt = ROUTE_SELF;
            end else if (in_rx_byte == ADDR_HOST) begin
              route_nxt        = ROUTE_HOST;
              job_base.has_tx  = 1'b1;
              job_base.tx_byte = in_rx_byte;
            end else if (in_rx_byte == ADDR_BCAST) begin
              route_nxt        = ROUTE_BCAST;
              job_base.has_tx  = 1'b1;
              job_base.tx_byte = in_rx_byte;
            end else begin
              route_nxt        = ROUTE_OTHER;
              job_base.has_tx  = 1'b1;
              job_base.tx_byte = in_rx_byte - 8'd1;
            end
          end
        endcase
      end
    end
  end

  // Colour decode from the updated store
  always_comb begin
    job          = job_base;
    job.cmd_code = cmd_nxt[7:3];
    job.red      = '0;
    job.green    = '0;
    job.blue     = '0;
    case (cmd_nxt[7:3])
      CODE_RGB8: begin
        job.red   = {8'd0, pad[0]};
        job.green = {8'd0, pad[1]};
        job.blue  = {8'd0, pad[2]};
      end
      CODE_RGB16: begin
        job.red   = {pad[1], pad[0]};
        job.green = {pad[3], pad[2]};
        job.blue  = {pad[5], pad[4]};
      end
      default: ;
    endcase
  end

  // Only items that cause results go into the queue
  assign push = in_acc && (job_base.err || job_base.has_tx || job_base.has_exec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      route_r <= ROUTE_SELF;
      cmd_r   <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) store_r[i] <= '0;
    end else begin
      phase_r <= phase_nxt;
      route_r <= route_nxt;
      cmd_r   <= cmd_nxt;
      count_r <= count_nxt;
      store_r <= store_nxt;
    end
  end

endmodule

### hw/rtl/dcpr_queue.sv
// Two-entry queue of work descriptors between front and back.
`timescale 1ns / 1ps
module dcpr_queue import dcpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic vld,
  output job_t head
);

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign vld  = (cnt_r != 2'd0);
  assign head = ent_r[rd_ptr_r];

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> vld) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
`endif

endmodule

### hw/rtl/dcpr_back.sv
// Back end: expands work descriptors into result transfers through an output register.
`timescale 1ns / 1ps
module dcpr_back import dcpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_vld,
  input  job_t        q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [4:0]  out_cmd_code,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level,
  output logic        out_last
);

  logic [1:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic        load, last_step;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [4:0]  code_r, code_nxt;
  logic [15:0] red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic        last_r;

  assign load = q_vld && (!valid_r || !out_stall);

  // Last result of the descriptor at the head
  always_comb begin
    if (q_head.err) last_step = (step_r == 2'd2);
    else            last_step = (step_r == 2'd1) || !(q_head.has_tx && q_head.has_exec);
  end

  assign q_pop    = load && last_step;
  assign step_nxt = q_pop ? 2'd0 : (load ? step_r + 2'd1 : step_r);

  // Result selection for the current step
  always_comb begin
    kind_nxt  = KIND_TX;
    tx_nxt    = '0;
    code_nxt  = '0;
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (q_head.err) begin
      case (step_r)
        2'd0:    tx_nxt = ADDR_BCAST;
        2'd1:    tx_nxt = RESET_CMD;
        default: kind_nxt = KIND_RST;
      endcase
    end else if (step_r == 2'd0 && q_head.has_tx) begin
      tx_nxt = q_head.tx_byte;
    end else begin
      kind_nxt  = KIND_EXEC;
      code_nxt  = q_head.cmd_code;
      red_nxt   = q_head.red;
      green_nxt = q_head.green;
      blue_nxt  = q_head.blue;
    end
  end

  assign valid_nxt = load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      tx_r    <= tx_nxt;
      code_r  <= code_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      last_r  <= last_step;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_tx_byte     = tx_r;
  assign out_cmd_code    = code_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;
  assign out_last        = last_r;

`ifndef SYNTH
  a_step_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (q_vld && !q_head.err) |-> (step_r != 2'd2 && step_r != 2'd3))
    else $error("normal descriptor beyond two results");
  a_err_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (load && q_head.err && step_r == 2'd0) |=> (step_r == 2'd1))
    else $error("error sequence did not advance");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !load)
    else $error("output register overwritten while stalled");
`endif

endmodule

### hw/rtl/daisy_chain_packet_router.sv
// A result passes through a queue entry and then the output register before it is offered.
// Throughput: one byte per cycle; the back emits one result per cycle, so a byte that
// causes two results, or an error byte (three results), holds the front off via the
// two-entry queue. Output stalls do not stop the front until the queue fills.
// Reset: synchronous active-low rst_n clears framing state, payload store and queue.
`timescale 1ns / 1ps
module daisy_chain_packet_router import dcpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [4:0]  out_cmd_code,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level,
  output logic        out_last
);

  logic in_acc, push, full, pop, q_vld;
  job_t push_job, head;

  assign in_stall = full;
  assign in_acc   = in_valid && !in_stall;

  // Framing and routing front
  dcpr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .job        (push_job)
  );

  // Decoupling queue
  dcpr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .vld      (q_vld),
    .head     (head)
  );

  // Result sequencer and output register
  dcpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_cmd_code    (out_cmd_code),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_last        (out_last)
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the daisy-chain packet router node.
`timescale 1ns / 1ps
module tb_top;
  import dcpr_pkg::*;

  localparam int MAX_PAYLOAD = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;

  // One result transfer as seen on the output channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [4:0]  cmd_code;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
  } router_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic [4:0]  out_cmd_code;
  logic [15:0] out_red_level;
  logic [15:0] out_green_level;
  logic [15:0] out_blue_level;
  logic        out_last;

  daisy_chain_packet_router #(.MAX_PAYLOAD(MAX_PAYLOAD)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_cmd_code    (out_cmd_code),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Predictor state: framing of the packet in progress
  phase_t     frame_phase = PH_ADDR;
  route_t     frame_route = ROUTE_SELF;
  logic [7:0] frame_command = 8'd0;
  int         frame_count = 0;
  logic [7:0] colour_bytes [STORE_SLOTS];

  router_result_t pending_results [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_start = 1'b0;
  int hold_len = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int bytes_sent = 0;
  int error_bytes = 0;
  int results_seen = 0;
  int exec_seen = 0;
  int mismatches = 0;

  function automatic router_result_t tx_result(input logic [7:0] b);
    router_result_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx_byte = b;
    return r;
  endfunction

  // Colour decode of the held command over the payload store
  function automatic router_result_t exec_result();
    router_result_t r;
    r = '0;
    r.kind = KIND_EXEC;
    r.cmd_code = frame_command[7:3];
    if (r.cmd_code == CODE_RGB8) begin
      r.red = {8'd0, colour_bytes[0]};
      r.green = {8'd0, colour_bytes[1]};
      r.blue = {8'd0, colour_bytes[2]};
    end else if (r.cmd_code == CODE_RGB16) begin
      r.red = {colour_bytes[1], colour_bytes[0]};
      r.green = {colour_bytes[3], colour_bytes[2]};
      r.blue = {colour_bytes[5], colour_bytes[4]};
    end
    return r;
  endfunction

  function automatic void clear_framing();
    frame_phase = PH_ADDR;
    frame_route = ROUTE_SELF;
    frame_command = 8'd0;
    frame_count = 0;
    for (int i = 0; i < STORE_SLOTS; i++) colour_bytes[i] = 8'd0;
  endfunction

  // Works out the result transfers that one accepted byte causes
  function automatic void predict_router_results(input logic op, input logic [7:0] b);
    router_result_t res [$];
    router_result_t rst_res;
    bit executes;
    res = {};
    executes = (frame_route == ROUTE_SELF) || (frame_route == ROUTE_BCAST);
    if (op) begin
      // receive error: broadcast reset downstream, then back to idle
      res.push_back(tx_result(ADDR_BCAST));
      res.push_back(tx_result(RESET_CMD));
      rst_res = '0;
      rst_res.kind = KIND_RST;
      res.push_back(rst_res);
      clear_framing();
    end else begin
      case (frame_phase)
        PH_CMD: begin
          frame_command = b;
          if (frame_route != ROUTE_SELF) res.push_back(tx_result(b));
          frame_count = 0;
          if (b[2:0] == 3'd0) begin
            if (executes) res.push_back(exec_result());
            frame_phase = PH_ADDR;
          end else begin
            frame_phase = PH_PAY;
          end
        end
        PH_PAY: begin
          if (frame_route != ROUTE_OTHER && frame_count < MAX_PAYLOAD &&
              frame_count < STORE_SLOTS)
            colour_bytes[frame_count] = b;
          if (frame_route != ROUTE_SELF) res.push_back(tx_result(b));
          frame_count = (frame_count + 1) % 8;
          if (frame_count == 0 || frame_count >= int'(frame_command[2:0])) begin
            if (executes) res.push_back(exec_result());
            frame_phase = PH_ADDR;
            frame_count = 0;
          end
        end
        default: begin
          if (b == ADDR_SELF) begin
            frame_route = ROUTE_SELF;
          end else if (b == ADDR_HOST) begin
            frame_route = ROUTE_HOST;
            res.push_back(tx_result(b));
          end else if (b == ADDR_BCAST) begin
            frame_route = ROUTE_BCAST;
            res.push_back(tx_result(b));
          end else begin
            frame_route = ROUTE_OTHER;
            res.push_back(tx_result(b - 8'd1));
          end
          frame_phase = PH_CMD;
        end
      endcase
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endfunction

  // Offers one byte, with random gaps, and waits for its transfer
  task automatic send_byte(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_router_results(op, b);
    bytes_sent++;
    if (op) error_bytes++;
  endtask

  task automatic send_error();
    send_byte(1'b1, 8'($urandom_range(255)));
  endtask

  // Well-formed packet with random content, now and then broken by an error byte
  task automatic send_random_packet();
    logic [7:0] addr;
    logic [4:0] code;
    logic [2:0] len;
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) addr = ADDR_SELF;
    else if (sel < 50) addr = ADDR_BCAST;
    else if (sel < 62) addr = ADDR_HOST;
    else if (sel < 70) addr = 8'd2;
    else addr = 8'($urandom_range(255));
    sel = $urandom_range(99);
    if (sel < 40) code = CODE_RGB8;
    else if (sel < 75) code = CODE_RGB16;
    else code = 5'($urandom_range(31));
    if ($urandom_range(1) == 0) len = (code == CODE_RGB8) ? 3'd3 :
                                      (code == CODE_RGB16) ? 3'd6 : 3'($urandom_range(7));
    else len = 3'($urandom_range(7));
    send_byte(1'b0, addr);
    if ($urandom_range(99) < 3) begin
      send_error();
      return;
    end
    send_byte(1'b0, {code, len});
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3) begin
        send_error();
        return;
      end
      send_byte(1'b0, 8'($urandom_range(255)));
    end
  endtask

  // Output side: random stall, or a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left = hold_len;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    router_result_t got;
    router_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_kind, out_tx_byte, out_cmd_code, out_red_level, out_green_level,
              out_blue_level, out_last};
      results_seen++;
      if (got.kind == KIND_EXEC) exec_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result kind=%0d tx=%02h code=%0d r=%04h g=%04h b=%04h last=%0b",
                   got.kind, got.tx_byte, got.cmd_code, got.red, got.green, got.blue,
                   got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d: expected kind=%0d tx=%02h code=%0d r=%04h ",
                      "g=%04h b=%04h last=%0b, got kind=%0d tx=%02h code=%0d r=%04h ",
                      "g=%04h b=%04h last=%0b"},
                     results_seen, want.kind, want.tx_byte, want.cmd_code, want.red,
                     want.green, want.blue, want.last, got.kind, got.tx_byte, got.cmd_code,
                     got.red, got.green, got.blue, got.last);
        end
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("daisy_chain_packet_router test failed");
      $finish;
    end
  end

  // Self, broadcast, host and decremented routing, extreme payload bytes
  task automatic test_routing();
    send_byte(1'b0, ADDR_SELF);
    send_byte(1'b0, {CODE_RGB8, 3'd3});
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, ADDR_BCAST);
    send_byte(1'b0, {CODE_RGB16, 3'd6});
    send_byte(1'b0, 8'hff);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'h34);
    send_byte(1'b0, 8'h12);
    send_byte(1'b0, 8'h01);
    send_byte(1'b0, 8'hfe);
    send_byte(1'b0, ADDR_HOST);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'd2);
    send_byte(1'b0, 8'h09);
    send_byte(1'b0, 8'ha5);
  endtask

  // Short payload keeps earlier colour bytes
  task automatic test_short_payload();
    send_byte(1'b0, ADDR_SELF);
    send_byte(1'b0, {CODE_RGB16, 3'd2});
    send_byte(1'b0, 8'h11);
    send_byte(1'b0, 8'h22);
  endtask

  // Error in the middle of nothing, then an unknown code with no payload
  task automatic test_receive_error();
    send_error();
    send_byte(1'b0, ADDR_SELF);
    send_byte(1'b0, 8'hf8);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(99) < 6) send_byte(1'b0, 8'($urandom_range(255)));
      else if ($urandom_range(99) < 4) send_error();
      else send_random_packet();
    end
  endtask

  // Long output hold-off while the sender keeps offering bytes
  task automatic test_backpressure();
    hold_len = 120;
    hold_start = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_byte(1'b0, ADDR_BCAST);
      send_byte(1'b0, {CODE_RGB8, 3'd3});
      send_byte(1'b0, 8'($urandom_range(255)));
      send_byte(1'b0, 8'($urandom_range(255)));
      send_byte(1'b0, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    clear_framing();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 45;
    test_routing();
    test_short_payload();
    test_receive_error();
    test_random_traffic(140);

    tx_idle_pct = 45;
    rx_idle_pct = 38;
    test_backpressure();
    test_random_traffic(110);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(120);
    in_valid <= 1'b0;

    // drain the outstanding results, then allow for late extras
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d with receive error) over three idling regimes and a hold-off.",
             bytes_sent, error_bytes);
    $display("Checked %0d result transfers, %0d of them executed packets; %0d mismatches.",
             results_seen, exec_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("daisy_chain_packet_router test passed");
    end else begin
      $display("daisy_chain_packet_router test failed");
    end
    $finish;
  end

endmodule

### daisy_chain_packet_router.f
hw/rtl/dcpr_pkg.sv
hw/rtl/dcpr_front.sv
hw/rtl/dcpr_queue.sv
hw/rtl/dcpr_back.sv
hw/rtl/daisy_chain_packet_router.sv
tb/tb_top.sv
